// ----- rtl/core/les_pkg.sv -----
// Shared types and constants of the LOOK elevator scheduler.
package les_pkg;

    localparam int FLOOR_W = 7;
    localparam int DIR_W   = 2;

    typedef logic [FLOOR_W-1:0] t_floor;

    typedef enum logic [DIR_W-1:0] {
        DIR_IDLE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    localparam logic CMD_REQUEST = 1'b0;
    localparam logic CMD_STEP    = 1'b1;

    // Register indexes on the configuration port (word address bit 2).
    localparam logic REG_NUM_FLOORS = 1'b0;

    // Outcome of one goal selection.
    typedef struct packed {
        t_dir   dir;
        t_floor goal;
    } t_goal;

endpackage

// ----- rtl/core/les_if.sv -----
// Valid/ready channel interfaces for request and result words.
interface les_req_if
    import les_pkg::*;
();
    logic   valid;
    logic   ready;
    logic   command;
    t_floor floor;
    logic   floor_vacant;

    modport source (output valid, output command, output floor, output floor_vacant,
                    input ready);
    modport sink   (input valid, input command, input floor, input floor_vacant,
                    output ready);
endinterface

interface les_res_if
    import les_pkg::*;
();
    logic   valid;
    logic   ready;
    t_floor current_floor;
    t_dir   direction;
    t_floor target_floor;

    modport source (output valid, output current_floor, output direction,
                    output target_floor, input ready);
    modport sink   (input valid, input current_floor, input direction,
                    input target_floor, output ready);
endinterface

// ----- rtl/core/look_elevator_scheduler_unit.sv -----
// LOOK elevator scheduler top level: input register, update logic and car state.
// The block takes one word per cycle, a floor request or a floor step, and answers each with
// one word holding the car's floor, direction and goal after that word. A word is held in
// the input register; the pending-floor update, the two priority encodes of the LOOK
// selection and the car move are combinational, and the car state doubles as the result
// register, so a result passes through the input register and then the car state, which
// waits while the result side stalls. A new word can follow every cycle while the result
// side keeps taking. The floor count is set
// through the APB-style port at address 0 (reset 64, values below 2 act as 2, above
// MAX_FLOORS as MAX_FLOORS) and should be written only while no word is in flight.
module look_elevator_scheduler_unit
    import les_pkg::*;
#(
    parameter int MAX_FLOORS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    les_req_if.sink     i_req,
    les_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (MAX_FLOORS > 1) ? $clog2(MAX_FLOORS) : 1;
    localparam logic [8:0] MAXF = 9'(MAX_FLOORS);

    t_floor num_floors;
    t_floor floors;

    logic   r_in_valid;
    logic   r_in_cmd;
    t_floor r_in_floor;
    logic   r_in_vacant;

    logic                  r_out_valid;
    logic [MAX_FLOORS-1:0] r_pend;
    t_floor                r_car;
    t_dir                  r_dir;
    t_floor                r_goal;

    logic [MAX_FLOORS-1:0] n_pend;
    t_floor                n_car;
    t_dir                  n_dir;
    t_floor                n_goal;

    logic             fire;
    logic             in_ready;
    logic             req_ok;
    logic             step_on;
    logic             do_sel;
    logic [FLOOR_W:0] req_m1;
    logic [FLOOR_W:0] car_m1;
    t_goal            sel;

    les_cfg_regs u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_num_floors (num_floors)
    );

    always_comb begin
        if (num_floors < 7'd2) begin
            floors = 7'd2;
        end else if ({2'b00, num_floors} > MAXF) begin
            floors = MAXF[FLOOR_W-1:0];
        end else begin
            floors = num_floors;
        end
    end

    assign fire     = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || fire;
    assign i_req.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_req.valid) begin
            r_in_cmd    <= i_req.command;
            r_in_floor  <= i_req.floor;
            r_in_vacant <= i_req.floor_vacant;
        end
    end

    assign req_ok  = (r_in_cmd == CMD_REQUEST) && (r_in_floor != '0) && (r_in_floor <= floors);
    assign step_on = (r_in_cmd == CMD_STEP) && (r_dir != DIR_IDLE);
    assign req_m1  = {1'b0, r_in_floor} - 8'd1;
    assign car_m1  = {1'b0, r_car} - 8'd1;

    // Pending bits as the selection must see them: new request set, vacant floor cleared.
    always_comb begin
        n_pend = r_pend;
        if (req_ok) begin
            n_pend[IDX_W'(req_m1)] = 1'b1;
        end
        if (step_on && r_in_vacant && ({2'b00, r_car} <= MAXF) && (r_car != '0)) begin
            n_pend[IDX_W'(car_m1)] = 1'b0;
        end
    end

    assign do_sel = (req_ok && (r_dir == DIR_IDLE)) || (step_on && (r_car == r_goal));

    les_look_select #(
        .MAX_FLOORS (MAX_FLOORS)
    ) u_select (
        .i_pending   (n_pend),
        .i_car_floor (r_car),
        .i_floors    (floors),
        .i_dir       (r_dir),
        .o_sel       (sel)
    );

    always_comb begin
        n_dir  = do_sel ? sel.dir : r_dir;
        n_goal = do_sel ? sel.goal : r_goal;
        n_car  = r_car;
        if (step_on) begin
            unique case (n_dir)
                DIR_UP: begin
                    if (r_car < floors) begin
                        n_car = r_car + 7'd1;
                    end
                end
                DIR_DOWN: begin
                    if (r_car > 7'd1) begin
                        n_car = r_car - 7'd1;
                    end
                end
                DIR_IDLE: begin
                    n_car = r_car;
                end
                default: begin
                    n_car = r_car;
                end
            endcase
        end
    end

    // The car state is the result word; it only changes when the output slot is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= '0;
            r_car       <= 7'd1;
            r_dir       <= DIR_IDLE;
            r_goal      <= '0;
        end else begin
            if (fire) begin
                r_out_valid <= 1'b1;
                r_pend      <= n_pend;
                r_car       <= n_car;
                r_dir       <= n_dir;
                r_goal      <= n_goal;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.current_floor = r_car;
    assign o_res.direction     = r_dir;
    assign o_res.target_floor  = r_goal;

`ifndef SYNTHESIS
    a_idle_no_goal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir == DIR_IDLE) |-> (r_goal == '0))
        else $error("idle car holds a goal floor");

    a_moving_has_goal : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dir != DIR_IDLE) |-> (r_goal != '0))
        else $error("moving car has no goal floor");

    a_car_above_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_car != '0)
        else $error("car floor dropped to zero");

    a_state_held_on_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_res.ready) |=> ($stable(r_car) && $stable(r_dir)
                                          && $stable(r_goal) && $stable(r_pend)))
        else $error("car state changed while the result word was stalled");

    a_ready_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled without a held word on both sides");
`endif

endmodule

// ----- rtl/core/les_cfg_regs.sv -----
// APB-style configuration register holding the floor count.
module les_cfg_regs
    import les_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output t_floor       o_num_floors
);

    t_floor r_num_floors;
    logic   wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_FLOORS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_floors <= 7'd64;
        end else if (wr_en) begin
            r_num_floors <= pwdata[FLOOR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_NUM_FLOORS) begin
            prdata = {{(32-FLOOR_W){1'b0}}, r_num_floors};
        end
    end

    assign o_num_floors = r_num_floors;

endmodule

// ----- rtl/core/les_look_select.sv -----
// LOOK goal selection: priority encodes up and down from the car's floor.
module les_look_select
    import les_pkg::*;
#(
    parameter int MAX_FLOORS = 64
) (
    input  logic [MAX_FLOORS-1:0] i_pending,
    input  t_floor                i_car_floor,
    input  t_floor                i_floors,
    input  t_dir                  i_dir,
    output t_goal                 o_sel
);

    // Floor numbers never exceed what the 7-bit floor count can name.
    localparam int SEARCH = (MAX_FLOORS < 127) ? MAX_FLOORS : 127;

    t_floor up_hit;
    t_floor down_hit;
    t_floor down_lim;

    assign down_lim = (i_car_floor > i_floors) ? i_floors : i_car_floor;

    // Lowest pending floor in [car, n]: scan downward so the lowest hit wins.
    always_comb begin
        logic [FLOOR_W:0] f;
        up_hit = '0;
        for (int i = SEARCH - 1; i >= 0; i--) begin
            f = (FLOOR_W+1)'(i + 1);
            if (i_pending[i] && (f >= {1'b0, i_car_floor}) && (f <= {1'b0, i_floors})) begin
                up_hit = f[FLOOR_W-1:0];
            end
        end
    end

    // Highest pending floor in [1, min(car, n)]: scan upward so the highest wins.
    always_comb begin
        logic [FLOOR_W:0] f;
        down_hit = '0;
        for (int i = 0; i < SEARCH; i++) begin
            f = (FLOOR_W+1)'(i + 1);
            if (i_pending[i] && (f <= {1'b0, down_lim})) begin
                down_hit = f[FLOOR_W-1:0];
            end
        end
    end

    always_comb begin
        o_sel.dir  = DIR_IDLE;
        o_sel.goal = '0;
        if (i_dir == DIR_DOWN) begin
            if (down_hit != '0) begin
                o_sel.dir  = DIR_DOWN;
                o_sel.goal = down_hit;
            end else if (up_hit != '0) begin
                o_sel.dir  = DIR_UP;
                o_sel.goal = up_hit;
            end
        end else begin
            if (up_hit != '0) begin
                o_sel.dir  = DIR_UP;
                o_sel.goal = up_hit;
            end else if (down_hit != '0) begin
                o_sel.dir  = DIR_DOWN;
                o_sel.goal = down_hit;
            end
        end
    end

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the LOOK elevator scheduler: directed rows, random traffic, own predictor.
module tb
    import les_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FLOORS     = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASES         = 12;
    localparam int PHASE_WORDS    = 150;

    localparam int RX_OPEN  = 0;
    localparam int RX_COIN  = 1;
    localparam int RX_BEAT  = 2;
    localparam int RX_CHOKE = 3;

    localparam logic [2:0] NUM_FLOORS_ADDR = {REG_NUM_FLOORS, 2'b00};

    typedef struct packed {
        t_floor car;
        t_dir   dir;
        t_floor goal;
    } t_car_view;

    typedef struct {
        bit        is_cfg;
        bit [6:0]  cfg_val;
        logic      cmd;
        t_floor    flr;
        logic      vac;
        bit        typed;
        t_car_view lit;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    les_req_if req_if();
    les_res_if res_if();

    look_elevator_scheduler_unit #(
        .MAX_FLOORS(MAX_FLOORS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted car state.
    bit [MAX_FLOORS:1] calls;
    t_floor            car_at;
    t_dir              heading;
    t_floor            aim;
    bit [6:0]          floors_reg;

    t_car_view views_due[$];
    t_car_view due_head;
    int        errors       = 0;
    int        quiet_cycles = 0;
    int        burst_left   = 0;
    int        rx_mode      = RX_OPEN;
    int        rx_left      = 0;
    int        rx_phase     = 0;

    always #10 i_clk = ~i_clk;

    function automatic int unsigned eff_floors(bit [6:0] v);
        if (v < 2) return 2;
        if (v > MAX_FLOORS) return MAX_FLOORS;
        return v;
    endfunction

    function automatic int unsigned scan_up(int unsigned from, int unsigned n);
        int unsigned f;
        for (f = (from < 1) ? 1 : from; f <= n; f++)
            if (calls[f]) return f;
        return 0;
    endfunction

    function automatic int unsigned scan_down(int unsigned from, int unsigned n);
        int f;
        for (f = (from > n) ? n : from; f >= 1; f--)
            if (calls[f]) return f;
        return 0;
    endfunction

    function automatic void pick_goal();
        int unsigned n;
        int unsigned t;
        n = eff_floors(floors_reg);
        if (heading == DIR_DOWN) begin
            t = scan_down(car_at, n);
            if (t == 0) begin
                t = scan_up(car_at, n);
                if (t != 0) heading = DIR_UP;
                else heading = DIR_IDLE;
            end
        end else begin
            t = scan_up(car_at, n);
            if (t != 0) begin
                heading = DIR_UP;
            end else begin
                t = scan_down(car_at, n);
                if (t != 0) heading = DIR_DOWN;
                else heading = DIR_IDLE;
            end
        end
        aim = t_floor'(t);
    endfunction

    function automatic t_car_view apply_word(logic cmd, t_floor flr, logic vac);
        int unsigned n;
        t_car_view   v;
        n = eff_floors(floors_reg);
        if (cmd == CMD_REQUEST) begin
            if (flr >= 1 && flr <= n) begin
                calls[flr] = 1'b1;
                if (heading == DIR_IDLE) pick_goal();
            end
        end else if (heading != DIR_IDLE) begin
            if (vac && car_at >= 1 && car_at <= MAX_FLOORS) calls[car_at] = 1'b0;
            if (car_at == aim) pick_goal();
            if (heading == DIR_UP) begin
                if (car_at < n) car_at++;
            end else if (heading == DIR_DOWN) begin
                if (car_at > 1) car_at--;
            end
        end
        v.car  = car_at;
        v.dir  = heading;
        v.goal = aim;
        return v;
    endfunction

    function automatic t_script_row word_row(logic cmd, t_floor flr, logic vac);
        t_script_row r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.cmd     = cmd;
        r.flr     = flr;
        r.vac     = vac;
        r.typed   = 1'b0;
        r.lit     = '0;
        return r;
    endfunction

    function automatic t_script_row lit_row(logic cmd, t_floor flr, logic vac,
                                            t_floor car, t_dir dir, t_floor goal);
        t_script_row r;
        r          = word_row(cmd, flr, vac);
        r.typed    = 1'b1;
        r.lit.car  = car;
        r.lit.dir  = dir;
        r.lit.goal = goal;
        return r;
    endfunction

    function automatic t_script_row cfg_row(bit [6:0] v);
        t_script_row r;
        r         = word_row(CMD_REQUEST, '0, 1'b0);
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        return r;
    endfunction

    function automatic bit [6:0] phase_floors(int ph);
        case (ph)
            0: return 7'd64;
            1: return 7'd2;
            2: return 7'd127;
            3: return 7'd0;
            4: return 7'd1;
            5: return 7'd65;
            default: begin
                if ($urandom_range(0, 3) == 0) return 7'($urandom_range(0, 127));
                return 7'($urandom_range(2, 12));
            end
        endcase
    endfunction

    task automatic log_miss(string what, int want, int got);
        errors++;
        if (errors <= 10)
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Sends one word in bursts with random gaps, then books its predicted result.
    task automatic put_word(logic cmd, t_floor flr, logic vac, bit typed, t_car_view lit);
        int        gap;
        t_car_view seen;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        req_if.valid        <= 1'b1;
        req_if.command      <= cmd;
        req_if.floor        <= flr;
        req_if.floor_vacant <= vac;
        do @(posedge i_clk); while (!req_if.ready);
        seen = apply_word(cmd, flr, vac);
        views_due.push_back(typed ? lit : seen);
    endtask

    task automatic wait_drain();
        req_if.valid <= 1'b0;
        while (views_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Write the floor count, then read it back in the following transfer.
    task automatic configure(bit [6:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= NUM_FLOORS_ADDR;
        pwdata  <= {25'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        floors_reg = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {25'd0, v}) log_miss("num_floors readback", v, prdata);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = $urandom_range(RX_OPEN, RX_CHOKE);
                rx_left = $urandom_range(32, 256);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_OPEN: res_if.ready <= 1'b1;
                RX_COIN: res_if.ready <= 1'($urandom_range(0, 1));
                RX_BEAT: res_if.ready <= (rx_phase % 5) != 0;
                default: res_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (res_if.valid && res_if.ready) begin
                if (views_due.size() == 0) begin
                    log_miss("unexpected word, current_floor", -1, res_if.current_floor);
                end else begin
                    due_head = views_due.pop_front();
                    if (res_if.current_floor !== due_head.car)
                        log_miss("current_floor", due_head.car, res_if.current_floor);
                    if (res_if.direction !== due_head.dir)
                        log_miss("direction", due_head.dir, res_if.direction);
                    if (res_if.target_floor !== due_head.goal)
                        log_miss("target_floor", due_head.goal, res_if.target_floor);
                end
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("look_elevator_scheduler_unit verification failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_script_row script[$];
        int          ph;
        int          k;
        int          pct;
        int unsigned n;
        bit [6:0]    v;
        logic        cmd;
        t_floor      flr;
        logic        vac;

        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.command      = CMD_REQUEST;
        req_if.floor        = '0;
        req_if.floor_vacant = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        calls               = '0;
        car_at              = 7'd1;
        heading             = DIR_IDLE;
        aim                 = '0;
        floors_reg          = 7'd64;

        // Idle car, requests outside the building, both ends of a two-floor shaft.
        script.push_back(lit_row(CMD_STEP, 7'd0, 1'b1, 7'd1, DIR_IDLE, 7'd0));
        script.push_back(lit_row(CMD_REQUEST, 7'd0, 1'b0, 7'd1, DIR_IDLE, 7'd0));
        script.push_back(lit_row(CMD_REQUEST, 7'd127, 1'b1, 7'd1, DIR_IDLE, 7'd0));
        script.push_back(cfg_row(7'd1));
        script.push_back(lit_row(CMD_REQUEST, 7'd3, 1'b0, 7'd1, DIR_IDLE, 7'd0));
        script.push_back(lit_row(CMD_REQUEST, 7'd2, 1'b0, 7'd1, DIR_UP, 7'd2));
        script.push_back(lit_row(CMD_REQUEST, 7'd1, 1'b1, 7'd1, DIR_UP, 7'd2));
        script.push_back(lit_row(CMD_STEP, 7'd64, 1'b1, 7'd2, DIR_UP, 7'd2));
        script.push_back(lit_row(CMD_STEP, 7'd0, 1'b0, 7'd2, DIR_UP, 7'd2));
        script.push_back(lit_row(CMD_STEP, 7'd0, 1'b1, 7'd2, DIR_IDLE, 7'd0));
        // Six floors: run up, reverse at the top, then shrink below the car.
        script.push_back(cfg_row(7'd6));
        script.push_back(lit_row(CMD_REQUEST, 7'd6, 1'b0, 7'd2, DIR_UP, 7'd6));
        script.push_back(lit_row(CMD_REQUEST, 7'd64, 1'b0, 7'd2, DIR_UP, 7'd6));
        script.push_back(word_row(CMD_REQUEST, 7'd1, 1'b0));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b0));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(cfg_row(7'd3));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(word_row(CMD_STEP, 7'd0, 1'b1));
        script.push_back(lit_row(CMD_STEP, 7'd0, 1'b0, 7'd1, DIR_DOWN, 7'd1));
        script.push_back(lit_row(CMD_STEP, 7'd0, 1'b1, 7'd1, DIR_IDLE, 7'd0));
        script.push_back(lit_row(CMD_REQUEST, 7'd1, 1'b0, 7'd1, DIR_UP, 7'd1));
        script.push_back(lit_row(CMD_STEP, 7'd0, 1'b1, 7'd1, DIR_IDLE, 7'd0));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                wait_drain();
                configure(script[i].cfg_val);
            end else begin
                put_word(script[i].cmd, script[i].flr, script[i].vac, script[i].typed,
                         script[i].lit);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            v = phase_floors(ph);
            // A smaller building must not leave the goal above the floors in use.
            for (k = 0; k < 400 && heading != DIR_IDLE && aim > eff_floors(v); k++)
                put_word(CMD_STEP, t_floor'($urandom_range(0, 127)), 1'b1, 1'b0, '0);
            wait_drain();
            configure(v);
            for (k = 0; k < PHASE_WORDS; k++) begin
                n = eff_floors(floors_reg);
                if ($urandom_range(0, 99) < 30) begin
                    cmd = CMD_REQUEST;
                    pct = $urandom_range(0, 99);
                    if (pct < 85)
                        flr = t_floor'($urandom_range(1, n));
                    else if (pct < 93)
                        flr = $urandom_range(0, 1) ? 7'd0 : t_floor'($urandom_range(n + 1, 127));
                    else
                        flr = t_floor'($urandom_range(0, 127));
                    vac = 1'($urandom_range(0, 1));
                end else begin
                    cmd = CMD_STEP;
                    flr = t_floor'($urandom_range(0, 127));
                    vac = ($urandom_range(0, 99) < 80);
                    // Keeping the goal call at the goal sends the car past it for good,
                    // except where the car already stands at the end of its travel.
                    if (heading == DIR_UP && car_at == aim && car_at < n) vac = 1'b1;
                    if (heading == DIR_DOWN && car_at == aim && car_at > 1) vac = 1'b1;
                end
                put_word(cmd, flr, vac, 1'b0, '0);
            end
        end

        wait_drain();
        if (errors == 0 && views_due.size() == 0)
            $display("look_elevator_scheduler_unit verification clean");
        else
            $display("look_elevator_scheduler_unit verification failed");
        $finish;
    end

endmodule
